// ----- hdl/pfm_pkg.sv -----
// Shared types, constants and request codes for the page frame manager.
package pfm_pkg;
	localparam int FRAMES_DEF       = 16;
	localparam int PAGE_ID_BITS_DEF = 32;
	localparam int MAX_RESULTS      = 16;
	localparam int PIN_BITS         = 16;

	localparam logic [2:0] REQ_FETCH = 3'd0;
	localparam logic [2:0] REQ_NEW   = 3'd1;
	localparam logic [2:0] REQ_UNPIN = 3'd2;
	localparam logic [2:0] REQ_FLUSH = 3'd3;
	localparam logic [2:0] REQ_ALL   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PINNED    = 2'd1;
	localparam logic [1:0] ST_NOT_RES   = 2'd2;
	localparam logic [1:0] ST_NOT_PINNED = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] page_id;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  frame;
		logic [31:0] result_page;
		logic        load_needed;
		logic        victim_write;
		logic [31:0] victim_page;
		logic        page_write;
		logic        last;
	} rsp_t;
endpackage

// ----- hdl/pfm_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface pfm_req_if;
	logic            valid;
	logic            ready;
	pfm_pkg::req_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pfm_rsp_if;
	logic            valid;
	logic            ready;
	pfm_pkg::rsp_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/page_frame_manager_lru_core.sv -----
// Page frame manager top level: frame table memory, free FIFO and LRU list.
//  channel | dir | payload
//  req     | in  | req_type, page_id, mark_dirty
//  rsp     | out | status, frame, result_page, load/victim/page write flags, last
//  cfg     | in  | cfg_we, cfg_data (first_page_id)
// One request is handled at a time; input is held off until its last word has left.
// A search reads the frame table memory one frame at a time, through a read state and
// a compare state; flush all sweeps the frames the same way. Free FIFO and LRU list
// updates visit one list entry per cycle. Reset clears control state and the valid/dirty
// bits; a table entry is written in the same cycle as its frame turns valid. A held
// result word stalls the sequencer.
module page_frame_manager_lru_core #(
	parameter int FRAMES       = pfm_pkg::FRAMES_DEF,
	parameter int PAGE_ID_BITS = pfm_pkg::PAGE_ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	pfm_req_if.sink     req,
	pfm_rsp_if.source   rsp
);
	localparam int FB = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CB = $clog2(FRAMES + 1);
	localparam logic [CB-1:0] FRAMES_C = CB'(FRAMES);
	localparam logic [PAGE_ID_BITS-1:0] PMAX = '1;
	localparam logic [pfm_pkg::PIN_BITS-1:0] PIN_MAX = '1;
	localparam logic [4:0] MAXR = 5'(pfm_pkg::MAX_RESULTS);
	localparam logic [FRAMES-1:0] ALL_FRAMES = '1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRD    = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_DISP   = 4'd3;
	localparam logic [3:0] S_LRURM  = 4'd4;
	localparam logic [3:0] S_TAKE   = 4'd5;
	localparam logic [3:0] S_QSHIFT = 4'd6;
	localparam logic [3:0] S_VRD    = 4'd7;
	localparam logic [3:0] S_ALLOC  = 4'd8;
	localparam logic [3:0] S_UPD    = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;
	localparam logic [3:0] S_FARD   = 4'd11;
	localparam logic [3:0] S_FACMP  = 4'd12;

	// frame table memory: page id and pin count
	logic [PAGE_ID_BITS-1:0]      page_mem [FRAMES];
	logic [pfm_pkg::PIN_BITS-1:0] pin_mem  [FRAMES];
	logic [PAGE_ID_BITS-1:0]      rd_page;
	logic [pfm_pkg::PIN_BITS-1:0] rd_pin;
	logic [FB-1:0]                rd_addr;
	logic                         wr_en;
	logic [FB-1:0]                wr_addr;
	logic [PAGE_ID_BITS-1:0]      wr_page;
	logic [pfm_pkg::PIN_BITS-1:0] wr_pin;

	logic [FRAMES-1:0] valid_q, dirty_q;
	logic [FB-1:0]     freeq_q [FRAMES];
	logic [FB-1:0]     lru_q   [FRAMES];
	logic [CB-1:0]     free_cnt_q, lru_cnt_q;
	logic [PAGE_ID_BITS-1:0] next_page_q;

	logic [3:0]  state_q;
	pfm_pkg::req_t r_q;
	logic [PAGE_ID_BITS-1:0] pid_q;
	logic [FB-1:0] idx_q, f_q;
	logic [CB-1:0] cnt_q;
	logic        found_q, vw_q;
	logic [PAGE_ID_BITS-1:0] vp_q;
	logic [4:0]  nres_q;
	logic        rsp_valid_q;
	pfm_pkg::rsp_t rsp_q;
	logic [FRAMES-1:0] later_dirty;
	logic        fa_last;

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem[wr_addr] <= wr_page;
			pin_mem[wr_addr]  <= wr_pin;
		end
		rd_page <= page_mem[rd_addr];
		rd_pin  <= pin_mem[rd_addr];
	end

	function automatic pfm_pkg::rsp_t mk(logic [1:0] st, logic [FB-1:0] fr,
			logic [PAGE_ID_BITS-1:0] pg, logic ld, logic vw,
			logic [PAGE_ID_BITS-1:0] vp, logic pw, logic lst);
		pfm_pkg::rsp_t o;
		o.status       = st;
		o.frame        = 4'(fr);
		o.result_page  = 32'(pg);
		o.load_needed  = ld;
		o.victim_write = vw;
		o.victim_page  = 32'(vp);
		o.page_write   = pw;
		o.last         = lst;
		return o;
	endfunction

	logic [FB-1:0] idx_last;
	assign idx_last = FB'(FRAMES - 1);

	// flush all: a word is final when no dirty frame lies above it or the cap is hit
	assign later_dirty = valid_q & dirty_q & ((ALL_FRAMES << idx_q) << 1);
	assign fa_last     = (nres_q + 1'b1 == MAXR) || (later_dirty == '0);

	// memory port control
	always_comb begin
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = f_q;
		wr_page = pid_q;
		wr_pin  = rd_pin;
		if (state_q == S_ALLOC) begin
			wr_en  = 1'b1;
			wr_pin = pfm_pkg::PIN_BITS'(1);
		end else if (state_q == S_UPD) begin
			wr_en   = 1'b1;
			wr_page = rd_page;
			if (r_q.req_type == pfm_pkg::REQ_FETCH)
				wr_pin = (rd_pin == PIN_MAX) ? rd_pin : rd_pin + 1'b1;
			else
				wr_pin = rd_pin - 1'b1;
		end
		if (state_q == S_TAKE || state_q == S_DISP)
			rd_addr = f_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			dirty_q     <= '0;
			free_cnt_q  <= FRAMES_C;
			lru_cnt_q   <= '0;
			next_page_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				freeq_q[i] <= FB'(i);
				lru_q[i]   <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			if (cfg_we)
				next_page_q <= PAGE_ID_BITS'(cfg_data);
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q     <= req.data;
						pid_q   <= PAGE_ID_BITS'(req.data.page_id);
						idx_q   <= '0;
						found_q <= 1'b0;
						vw_q    <= 1'b0;
						vp_q    <= '0;
						nres_q  <= '0;
						case (req.data.req_type) inside
							pfm_pkg::REQ_NEW: begin
								pid_q       <= next_page_q;
								next_page_q <= (next_page_q + 1'b1) & PMAX;
								state_q     <= S_TAKE;
							end
							pfm_pkg::REQ_ALL: state_q <= S_FARD;
							pfm_pkg::REQ_FETCH, pfm_pkg::REQ_UNPIN,
							pfm_pkg::REQ_FLUSH: state_q <= S_SRD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SRD: state_q <= S_SCMP; // read of idx_q in flight
				S_SCMP: begin
					if (valid_q[idx_q] && rd_page == pid_q) begin
						found_q <= 1'b1;
						f_q     <= idx_q;
						state_q <= S_DISP;
					end else if (idx_q == idx_last) begin
						state_q <= S_DISP;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_DISP: begin
					// rd_pin valid here for f_q when found (re-read from SCMP)
					if (!found_q) begin
						if (r_q.req_type == pfm_pkg::REQ_FETCH) begin
							state_q <= S_TAKE;
						end else begin
							rsp_q <= mk(pfm_pkg::ST_NOT_RES, '0, pid_q, 1'b0, 1'b0, '0,
								1'b0, 1'b1);
							state_q <= S_EMIT;
						end
					end else if (r_q.req_type == pfm_pkg::REQ_FLUSH) begin
						rsp_q <= mk(pfm_pkg::ST_OK, f_q, pid_q, 1'b0, 1'b0, '0,
							dirty_q[f_q], 1'b1);
						dirty_q[f_q] <= 1'b0;
						state_q <= S_EMIT;
					end else if (r_q.req_type == pfm_pkg::REQ_UNPIN) begin
						if (rd_pin == '0) begin
							rsp_q <= mk(pfm_pkg::ST_NOT_PINNED, f_q, pid_q, 1'b0, 1'b0, '0,
								1'b0, 1'b1);
							state_q <= S_EMIT;
						end else begin
							if (r_q.mark_dirty) dirty_q[f_q] <= 1'b1;
							if (rd_pin == pfm_pkg::PIN_BITS'(1) && lru_cnt_q < FRAMES_C) begin
								lru_q[lru_cnt_q[FB-1:0]] <= f_q;
								lru_cnt_q <= lru_cnt_q + 1'b1;
							end
							state_q <= S_UPD;
						end
					end else begin
						cnt_q   <= '0;
						state_q <= (rd_pin == '0) ? S_LRURM : S_UPD;
					end
				end
				S_LRURM: begin
					// one list slot a cycle: find f_q then shift the tail down
					if (cnt_q >= lru_cnt_q) begin
						state_q <= S_UPD;
					end else if (!vw_q) begin
						if (lru_q[cnt_q[FB-1:0]] == f_q) vw_q <= 1'b1;
						else cnt_q <= cnt_q + 1'b1;
					end else if (cnt_q + 1'b1 < lru_cnt_q) begin
						lru_q[cnt_q[FB-1:0]] <= lru_q[FB'(cnt_q + 1'b1)];
						cnt_q <= cnt_q + 1'b1;
					end else begin
						lru_cnt_q <= lru_cnt_q - 1'b1;
						vw_q      <= 1'b0;
						state_q   <= S_UPD;
					end
				end
				S_TAKE: begin
					cnt_q <= '0;
					if (free_cnt_q != '0) begin
						f_q <= freeq_q[0];
						found_q <= 1'b0;
						state_q <= S_QSHIFT;
					end else if (lru_cnt_q == '0) begin
						rsp_q <= mk(pfm_pkg::ST_PINNED, '0, pid_q, 1'b0, 1'b0, '0,
							1'b0, 1'b1);
						state_q <= S_EMIT;
					end else begin
						f_q <= lru_q[0];
						idx_q <= lru_q[0];
						found_q <= 1'b1;
						state_q <= S_QSHIFT;
					end
				end
				S_QSHIFT: begin
					if (!found_q) begin
						if (cnt_q + 1'b1 < free_cnt_q) begin
							freeq_q[cnt_q[FB-1:0]] <= freeq_q[FB'(cnt_q + 1'b1)];
							cnt_q <= cnt_q + 1'b1;
						end else begin
							free_cnt_q <= free_cnt_q - 1'b1;
							state_q    <= S_ALLOC;
						end
					end else begin
						if (cnt_q + 1'b1 < lru_cnt_q) begin
							lru_q[cnt_q[FB-1:0]] <= lru_q[FB'(cnt_q + 1'b1)];
							cnt_q <= cnt_q + 1'b1;
						end else begin
							lru_cnt_q <= lru_cnt_q - 1'b1;
							state_q   <= S_VRD;
						end
					end
				end
				S_VRD: begin
					// read of victim page issued when idx_q was set; data ready
					vw_q <= valid_q[f_q] && dirty_q[f_q];
					vp_q <= (valid_q[f_q] && dirty_q[f_q]) ? rd_page : '0;
					state_q <= S_ALLOC;
				end
				S_ALLOC: begin
					valid_q[f_q] <= 1'b1;
					dirty_q[f_q] <= (r_q.req_type == pfm_pkg::REQ_NEW);
					if (r_q.req_type == pfm_pkg::REQ_NEW)
						rsp_q <= mk(pfm_pkg::ST_OK, f_q, pid_q, 1'b0, vw_q, vp_q, 1'b1, 1'b1);
					else
						rsp_q <= mk(pfm_pkg::ST_OK, f_q, pid_q, 1'b1, vw_q, vp_q, 1'b0, 1'b1);
					state_q <= S_EMIT;
				end
				S_UPD: begin
					rsp_q <= mk(pfm_pkg::ST_OK, f_q, pid_q, 1'b0, 1'b0, '0, 1'b0, 1'b1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!rsp_valid_q) begin
						rsp_valid_q <= 1'b1;
						state_q     <= (r_q.req_type == pfm_pkg::REQ_ALL && !rsp_q.last)
							? S_FARD : S_IDLE;
						if (r_q.req_type == pfm_pkg::REQ_ALL && !rsp_q.last)
							idx_q <= idx_q + 1'b1;
					end
				end
				S_FARD: state_q <= S_FACMP;
				S_FACMP: begin
					// wait until the previous word has left the output register
					if (!rsp_valid_q) begin
						if (valid_q[idx_q] && dirty_q[idx_q] && nres_q < MAXR) begin
							dirty_q[idx_q] <= 1'b0;
							nres_q  <= nres_q + 1'b1;
							rsp_q   <= mk(pfm_pkg::ST_OK, idx_q, rd_page, 1'b0, 1'b0, '0,
								1'b1, fa_last);
							state_q <= S_EMIT;
						end else if (idx_q == idx_last) begin
							// reached only when no dirty frame was found
							rsp_q   <= mk(pfm_pkg::ST_OK, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
							state_q <= S_EMIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_FARD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/pfm_checker.sv -----
// Port-level checker for the page frame manager, bound to the top level.
module pfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [2:0]  req_type,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_last,
	input logic [1:0]  rsp_status
);
	logic open_q;
	// unknown request codes are taken without any result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) open_q <= 1'b0;
		else if (req_valid && req_ready && req_type <= pfm_pkg::REQ_ALL) open_q <= 1'b1;
		else if (rsp_valid && rsp_ready && rsp_last) open_q <= 1'b0;
	end

	a_no_accept_open: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> !req_ready) else $error("request taken while one is open");
	a_rsp_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q) else $error("result without request");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_last))
		else $error("result dropped while stalled");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != pfm_pkg::ST_OK |-> rsp_last)
		else $error("error result not final");
endmodule

bind page_frame_manager_lru_core pfm_checker u_pfm_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_type(req.data.req_type),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_last(rsp.data.last), .rsp_status(rsp.data.status)
);
